/* hdl/btalu_pkg.sv */
// Package for the balanced-ternary ALU: trit word sizes, operation codes,
// conversion constants and the stage record handed from cell to cell.
// No dependencies.
package btalu_pkg;

  // Word geometry
  localparam int TRITS  = 6;
  localparam int WORD_W = 2 * TRITS;
  localparam int BIN_W  = 10;

  // 3^n, evaluated at elaboration only
  function automatic int pow3(input int n);
    int p;
    p = 1;
    for (int i = 0; i < n; i++) begin
      p = p * 3;
    end
    return p;
  endfunction

  localparam int POW_T = pow3(TRITS);
  localparam int LIMIT = (POW_T - 1) / 2;
  // Offset value u = v + LIMIT lies in 0 .. 3^TRITS - 1
  localparam int U_W   = $clog2(POW_T);
  localparam int TOP_W = pow3(TRITS - 1);

  // Digit thresholds for the most significant ternary digit of u
  localparam logic [U_W-1:0] W1 = U_W'(TOP_W);
  localparam logic [U_W-1:0] W2 = U_W'(2 * TOP_W);

  // Operation codes
  localparam logic [1:0] FUNC_CONV = 2'd0;
  localparam logic [1:0] FUNC_ADD  = 2'd1;
  localparam logic [1:0] FUNC_SUB  = 2'd2;

  // Trit codes
  localparam logic [1:0] TRIT_ZERO = 2'b00;
  localparam logic [1:0] TRIT_POS  = 2'b01;
  localparam logic [1:0] TRIT_NEG  = 2'b11;

  // Record that travels down the chain of cells
  typedef struct packed {
    logic [1:0]        func;
    logic [WORD_W-1:0] x;      // shifts right one trit per cell
    logic [WORD_W-1:0] y;      // shifts right one trit per cell
    logic [U_W-1:0]    u;      // remaining convert value, scaled by 3 per cell
    logic signed [1:0] carry;
    logic              rerr;
    logic [WORD_W-1:0] res;
  } stage_t;

  // Input trit code to signed value; unused code reads as zero
  function automatic logic signed [1:0] trit_val(input logic [1:0] code);
    logic signed [1:0] t;
    case (code)
      TRIT_POS: t = 2'sd1;
      TRIT_NEG: t = -2'sd1;
      default:  t = 2'sd0;
    endcase
    return t;
  endfunction

endpackage

/* hdl/btalu_if.sv */
// Valid/ready channel interfaces for the balanced-ternary ALU.
// Depends on btalu_pkg.
interface btalu_in_if;
  import btalu_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [1:0]              func;
  logic signed [BIN_W-1:0] bin_value;
  logic [WORD_W-1:0]       x_trits;
  logic [WORD_W-1:0]       y_trits;

  modport source (output valid, output func, output bin_value, output x_trits,
                  output y_trits, input ready);
  modport sink   (input valid, input func, input bin_value, input x_trits,
                  input y_trits, output ready);
endinterface

interface btalu_out_if;
  import btalu_pkg::*;
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] result_trits;
  logic              carry_overflow;
  logic              range_error;

  modport source (output valid, output result_trits, output carry_overflow,
                  output range_error, input ready);
  modport sink   (input valid, input result_trits, input carry_overflow,
                  input range_error, output ready);
endinterface

/* hdl/btalu_cell.sv */
// One cell of the ALU chain: one ripple-carry trit for add/subtract and
// one ternary digit (most significant first) for convert, plus a stage register.
// Depends on btalu_pkg.
module btalu_cell
  import btalu_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   in_valid,
  output logic   in_ready,
  input  stage_t in_data,
  output logic   out_valid,
  input  logic   out_ready,
  output stage_t out_data
);

  logic              vld;
  stage_t            data;
  stage_t            data_next;

  logic signed [1:0] a;
  logic signed [1:0] b;
  logic signed [1:0] bn;
  logic signed [2:0] s;
  logic signed [1:0] carry_next;
  logic [1:0]        add_code;
  logic [1:0]        conv_code;
  logic [U_W-1:0]    r;
  logic              is_arith;

  // Add/subtract: one trit of the carry ripple
  always_comb begin
    a  = trit_val(in_data.x[1:0]);
    b  = trit_val(in_data.y[1:0]);
    bn = (in_data.func == FUNC_SUB) ? 2'(~b + 2'sd1) : b;
    s  = {a[1], a} + {bn[1], bn} + {in_data.carry[1], in_data.carry};
    carry_next = 2'sd0;
    if (s > 3'sd1) begin
      s = s - 3'sd3;
      carry_next = 2'sd1;
    end else if (s < -3'sd1) begin
      s = s + 3'sd3;
      carry_next = -2'sd1;
    end
    add_code = s[1:0];
  end

  // Convert: next ternary digit of u, balanced by subtracting one
  always_comb begin
    if (in_data.u >= W2) begin
      conv_code = TRIT_POS;
      r = in_data.u - W2;
    end else if (in_data.u >= W1) begin
      conv_code = TRIT_ZERO;
      r = in_data.u - W1;
    end else begin
      conv_code = TRIT_NEG;
      r = in_data.u;
    end
  end

  // Assemble the record for the next cell
  always_comb begin
    is_arith = (in_data.func == FUNC_ADD) || (in_data.func == FUNC_SUB);
    data_next       = in_data;
    data_next.x     = in_data.x >> 2;
    data_next.y     = in_data.y >> 2;
    data_next.u     = U_W'({r, 1'b0}) + r;
    data_next.carry = is_arith ? carry_next : 2'sd0;
    if (in_data.func == FUNC_CONV) begin
      data_next.res = {in_data.res[WORD_W-3:0], in_data.rerr ? TRIT_ZERO : conv_code};
    end else begin
      data_next.res = {is_arith ? add_code : TRIT_ZERO, in_data.res[WORD_W-1:2]};
    end
  end

  // Stage register; takes a beat when empty or when the neighbor drains it
  assign in_ready = !vld || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (in_ready) begin
      vld <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data <= data_next;
    end
  end

  assign out_valid = vld;
  assign out_data  = data;

endmodule

/* hdl/balanced_ternary_alu_core.sv */
// Six-trit balanced-ternary ALU: convert, add, subtract over a chain of
// TRITS cells, one trit per cell. One beat per cycle sustained while the
// output channel is ready, set by the per-cell stage registers with a ready
// chain that fills bubbles. Synchronous reset empties all stages; payload
// registers are not reset.
// Depends on btalu_pkg, btalu_if and btalu_cell.
module balanced_ternary_alu_core
  import btalu_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  btalu_in_if.sink     in_ch,
  btalu_out_if.source  out_ch
);

  stage_t      head;
  int          vi;
  logic        out_of_range;

  logic        vld   [TRITS+1];
  logic        rdy   [TRITS+1];
  stage_t      chain [TRITS+1];

  // Entry: range check and offset of the convert value
  always_comb begin
    vi = int'(in_ch.bin_value);
    out_of_range = (vi > LIMIT) || (vi < -LIMIT);
    head.func  = in_ch.func;
    head.x     = in_ch.x_trits;
    head.y     = in_ch.y_trits;
    head.u     = out_of_range ? '0 : U_W'(vi + LIMIT);
    head.carry = 2'sd0;
    head.rerr  = (in_ch.func == FUNC_CONV) && out_of_range;
    head.res   = '0;
  end

  assign vld[0]     = in_ch.valid;
  assign chain[0]   = head;
  assign in_ch.ready = rdy[0];

  // Chain of trit cells
  for (genvar k = 0; k < TRITS; k++) begin : g_cell
    btalu_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (vld[k]),
      .in_ready  (rdy[k]),
      .in_data   (chain[k]),
      .out_valid (vld[k+1]),
      .out_ready (rdy[k+1]),
      .out_data  (chain[k+1])
    );
  end

  // Result beat straight from the last stage register
  assign rdy[TRITS]           = out_ch.ready;
  assign out_ch.valid          = vld[TRITS];
  assign out_ch.result_trits   = chain[TRITS].res;
  assign out_ch.carry_overflow = (chain[TRITS].carry != 2'sd0);
  assign out_ch.range_error    = chain[TRITS].rerr;

endmodule

/* bench/testbench.sv */
// Self-checking bench for the balanced-ternary ALU core: directed table, then random beats,
// with random stalls on both channels and one long output hold-off.
// Depends on btalu_pkg, btalu_if and balanced_ternary_alu_core.
module testbench;
  import btalu_pkg::*;

  localparam int           CYCLE_LIMIT = 200000;
  localparam int           RAND_ITEMS  = 500;
  localparam int           DIR_N       = 23;
  localparam int           CONV_MAX    = (3 ** TRITS - 1) / 2;
  localparam int           HOLD_CYCLES = 300;
  localparam logic [1:0]   FUNC_NONE   = 2'd3;   // unused selector

  typedef struct packed {
    logic [WORD_W-1:0] trits;
    logic              ovf;
    logic              rerr;
  } alu_result_t;

  typedef struct packed {
    logic [1:0]              func;
    logic signed [BIN_W-1:0] bin;
    logic [WORD_W-1:0]       x;
    logic [WORD_W-1:0]       y;
    logic                    typed;   // expected result written in the row
    alu_result_t             want;
  } stim_row_t;

  logic clk;
  logic rst;

  btalu_in_if  in_ch ();
  btalu_out_if out_ch ();

  balanced_ternary_alu_core dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  alu_result_t pending_results [$];
  logic        cur_typed;
  alu_result_t cur_want;
  int          mismatches;
  int          results_seen;
  int          cycles;

  // Clock
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Trit code to value, code 2 reads as zero
  function automatic int trit_of(input logic [1:0] code);
    if (code == TRIT_POS) return 1;
    if (code == TRIT_NEG) return -1;
    return 0;
  endfunction

  function automatic logic [1:0] code_of(input int t);
    if (t > 0) return TRIT_POS;
    if (t < 0) return TRIT_NEG;
    return TRIT_ZERO;
  endfunction

  // Expected result of one beat
  function automatic alu_result_t bt_compute(input logic [1:0] func,
                                             input logic signed [BIN_W-1:0] bin,
                                             input logic [WORD_W-1:0] x,
                                             input logic [WORD_W-1:0] y);
    alu_result_t r;
    int v, rem, t, s, b, carry;
    r = '0;
    case (func)
      FUNC_CONV: begin
        v = bin;
        if (v > CONV_MAX || v < -CONV_MAX) begin
          r.rerr = 1'b1;
        end else begin
          for (int i = 0; i < TRITS; i++) begin
            rem = v % 3;
            if (rem < 0) rem += 3;
            t = (rem == 2) ? -1 : rem;
            r.trits[2*i +: 2] = code_of(t);
            v = (v - t) / 3;
          end
        end
      end
      FUNC_ADD, FUNC_SUB: begin
        carry = 0;
        for (int i = 0; i < TRITS; i++) begin
          b = trit_of(y[2*i +: 2]);
          if (func == FUNC_SUB) b = -b;
          s = trit_of(x[2*i +: 2]) + b + carry;
          carry = 0;
          if (s > 1) begin
            s -= 3;
            carry = 1;
          end else if (s < -1) begin
            s += 3;
            carry = -1;
          end
          r.trits[2*i +: 2] = code_of(s);
        end
        r.ovf = (carry != 0);
      end
      default: ;
    endcase
    return r;
  endfunction

  // Directed stimulus table
  function automatic stim_row_t directed_row(input int idx);
    stim_row_t r;
    r = '0;
    case (idx)
      0:  r = '{FUNC_CONV, 10'sd0,    12'h000, 12'h000, 1'b1, '{12'h000, 1'b0, 1'b0}};
      1:  r = '{FUNC_CONV, 10'sd364,  12'h000, 12'h000, 1'b1, '{12'h555, 1'b0, 1'b0}};
      2:  r = '{FUNC_CONV, -10'sd364, 12'h000, 12'h000, 1'b1, '{12'hFFF, 1'b0, 1'b0}};
      3:  r = '{FUNC_CONV, 10'sd365,  12'h000, 12'h000, 1'b1, '{12'h000, 1'b0, 1'b1}};
      4:  r = '{FUNC_CONV, -10'sd365, 12'hFFF, 12'hFFF, 1'b1, '{12'h000, 1'b0, 1'b1}};
      5:  r = '{FUNC_CONV, 10'sd511,  12'h555, 12'hAAA, 1'b1, '{12'h000, 1'b0, 1'b1}};
      6:  r = '{FUNC_CONV, -10'sd512, 12'hAAA, 12'h555, 1'b1, '{12'h000, 1'b0, 1'b1}};
      // convert ignores both operands
      7:  r = '{FUNC_CONV, 10'sd1,    12'hFFF, 12'hAAA, 1'b1, '{12'h001, 1'b0, 1'b0}};
      8:  r = '{FUNC_CONV, -10'sd1,   12'h555, 12'hFFF, 1'b1, '{12'h003, 1'b0, 1'b0}};
      9:  r = '{FUNC_CONV, 10'sd100,  12'h000, 12'h000, 1'b0, '0};
      10: r = '{FUNC_CONV, -10'sd200, 12'h000, 12'h000, 1'b0, '0};
      11: r = '{FUNC_ADD,  10'sd0,    12'h000, 12'h000, 1'b1, '{12'h000, 1'b0, 1'b0}};
      12: r = '{FUNC_ADD,  10'sd0,    12'h555, 12'h555, 1'b0, '0};
      13: r = '{FUNC_ADD,  -10'sd512, 12'hFFF, 12'hFFF, 1'b0, '0};
      14: r = '{FUNC_SUB,  10'sd511,  12'h555, 12'hFFF, 1'b0, '0};
      15: r = '{FUNC_SUB,  10'sd0,    12'hFFF, 12'h555, 1'b0, '0};
      // code 2 in every trit reads as zero
      16: r = '{FUNC_ADD,  10'sd511,  12'hAAA, 12'hAAA, 1'b1, '{12'h000, 1'b0, 1'b0}};
      17: r = '{FUNC_SUB,  10'sd0,    12'hAAA, 12'h555, 1'b0, '0};
      18: r = '{FUNC_ADD,  10'sd0,    12'h555, 12'h001, 1'b0, '0};
      19: r = '{FUNC_SUB,  10'sd0,    12'h000, 12'h001, 1'b0, '0};
      // unused selector gives all zero
      20: r = '{FUNC_NONE, 10'sd364,  12'hFFF, 12'h555, 1'b1, '{12'h000, 1'b0, 1'b0}};
      21: r = '{FUNC_ADD,  10'sd0,    12'h155, 12'h3C3, 1'b0, '0};
      22: r = '{FUNC_SUB,  10'sd0,    12'h5F3, 12'h5F3, 1'b1, '{12'h000, 1'b0, 1'b0}};
      default: ;
    endcase
    return r;
  endfunction

  // Idle length: mostly none or short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Drive one input beat and hold it until accepted
  task automatic send_beat(input stim_row_t row, input int gap);
    if (gap > 0) begin
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.func      = row.func;
    in_ch.bin_value = row.bin;
    in_ch.x_trits   = row.x;
    in_ch.y_trits   = row.y;
    cur_typed       = row.typed;
    cur_want        = row.want;
    in_ch.valid     = 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  // Cycle limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("testbench: FAIL");
      $finish;
    end
  end

  // Input beats queue an expectation, output beats are checked against the oldest
  always @(posedge clk) begin : scoreboard
    alu_result_t want, got;
    if (!rst && in_ch.valid && in_ch.ready) begin
      pending_results.insert(pending_results.size(), cur_typed ? cur_want :
          bt_compute(in_ch.func, in_ch.bin_value, in_ch.x_trits, in_ch.y_trits));
    end
    if (!rst && out_ch.valid && out_ch.ready) begin
      got = '{out_ch.result_trits, out_ch.carry_overflow, out_ch.range_error};
      results_seen = results_seen + 1;
      if (pending_results.size() == 0) begin
        if (mismatches < 10)
          $display("unexpected result beat: trits=%h ovf=%b rerr=%b",
                   got.trits, got.ovf, got.rerr);
        mismatches = mismatches + 1;
      end else begin
        want = pending_results.pop_front();
        if (got.trits !== want.trits || got.ovf !== want.ovf || got.rerr !== want.rerr) begin
          if (mismatches < 10)
            $display("mismatch: trits exp=%h got=%h  ovf exp=%b got=%b  rerr exp=%b got=%b",
                     want.trits, got.trits, want.ovf, got.ovf, want.rerr, got.rerr);
          mismatches = mismatches + 1;
        end
      end
    end
  end

  // Output side: random stalls, one long hold-off once traffic is flowing
  initial begin : receiver
    int run;
    bit held;
    held = 1'b0;
    out_ch.ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (!held && results_seen >= 150) begin
        out_ch.ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        held = 1'b1;
      end else begin
        run = pick_gap();
        if (run > 0) begin
          out_ch.ready = 1'b0;
          repeat (run) @(negedge clk);
        end
        out_ch.ready = 1'b1;
        run = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 16);
        repeat (run) @(negedge clk);
      end
    end
  end

  // Main sequence
  initial begin : stimulus
    stim_row_t row;
    int        sel, gap;
    rst             = 1'b1;
    in_ch.valid     = 1'b0;
    in_ch.func      = FUNC_CONV;
    in_ch.bin_value = '0;
    in_ch.x_trits   = '0;
    in_ch.y_trits   = '0;
    cur_typed       = 1'b0;
    cur_want        = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed part
    for (int i = 0; i < DIR_N; i++) begin
      send_beat(directed_row(i), pick_gap());
    end

    // Random part
    for (int n = 0; n < RAND_ITEMS; n++) begin
      row = '0;
      sel = $urandom_range(0, 99);
      if (sel < 30)      row.func = FUNC_CONV;
      else if (sel < 60) row.func = FUNC_ADD;
      else if (sel < 92) row.func = FUNC_SUB;
      else               row.func = FUNC_NONE;
      sel = $urandom_range(0, 9);
      if (sel < 6)       row.bin = BIN_W'($urandom_range(0, 2 * CONV_MAX) - CONV_MAX);
      else if (sel < 8)  row.bin = BIN_W'($urandom_range(0, 6) + CONV_MAX - 3);
      else if (sel < 9)  row.bin = BIN_W'(-CONV_MAX + 3 - $urandom_range(0, 6));
      else               row.bin = BIN_W'($urandom);
      row.x = WORD_W'($urandom);
      row.y = WORD_W'($urandom);
      // mostly clean trit words, code 2 folded into minus one
      if ($urandom_range(0, 3) != 0) begin
        for (int i = 0; i < TRITS; i++) begin
          if (row.x[2*i +: 2] == 2'b10) row.x[2*i +: 2] = TRIT_NEG;
          if (row.y[2*i +: 2] == 2'b10) row.y[2*i +: 2] = TRIT_NEG;
        end
      end
      // back-to-back bursts at regular windows
      gap = (n % 128 < 24) ? 0 : pick_gap();
      send_beat(row, gap);
    end
    in_ch.valid = 1'b0;

    // Drain
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4 * TRITS) @(posedge clk);
    if (mismatches == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
